### sv/slbm_pkg.sv
// Shared types and constants for the serial-loaded bank mapper.
package slbm_pkg;

   localparam int ADDR_W      = 16;
   localparam int VALUE_W     = 8;
   localparam int PHYS_W      = 18;
   localparam int REG_W       = 5;
   localparam int PRG_MASK_W  = 4;
   localparam int CHR_MASK_W  = 5;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_PRG   = 2'd1,
      KIND_CHR   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SEL_CONTROL  = 2'd0,
      SEL_CHR_LOW  = 2'd1,
      SEL_CHR_HIGH = 2'd2,
      SEL_PRG      = 2'd3
   } reg_sel_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_MASK = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_MASK = 1'b1;

   localparam logic [REG_W-1:0]      CONTROL_RESET  = 5'h0C;
   localparam logic [REG_W-1:0]      PRG_MODE_BITS  = 5'h0C;
   localparam logic [REG_W-1:0]      BANK_RESET     = 5'h1F;
   localparam logic [PRG_MASK_W-1:0] PRG_MASK_RESET = 4'd7;
   localparam logic [CHR_MASK_W-1:0] CHR_MASK_RESET = 5'd1;
   localparam logic [2:0]            LAST_BIT       = 3'd4;

   typedef struct packed {
      logic [REG_W-1:0] control;
      logic [REG_W-1:0] chr_low;
      logic [REG_W-1:0] chr_high;
      logic [REG_W-1:0] prg;
   } bank_state_type;

endpackage

### sv/slbm_loader.sv
// Serial shift register and the four bank registers it loads.
module slbm_loader (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          process,
   input  slbm_pkg::kind_type            kind,
   input  logic [slbm_pkg::ADDR_W-1:0]   addr,
   input  logic [slbm_pkg::VALUE_W-1:0]  value,
   output slbm_pkg::bank_state_type      state,
   output logic [1:0]                    mirroring,
   output logic                          committed
);
   import slbm_pkg::*;

   logic [REG_W-1:0] shift_ff, shift_in, shift_new;
   logic [2:0]       count_ff, count_in;
   bank_state_type   bank_ff, bank_in;
   logic             commit_in;

   always_comb begin
      shift_in  = shift_ff;
      count_in  = count_ff;
      bank_in   = bank_ff;
      commit_in = 1'b0;
      shift_new = shift_ff | (REG_W'(value[0]) << count_ff);
      if (process && (kind == KIND_WRITE) && addr[15]) begin
         if (value[7]) begin
            shift_in        = '0;
            count_in        = '0;
            bank_in.control = bank_ff.control | PRG_MODE_BITS;
         end else if (count_ff >= LAST_BIT) begin
            shift_in  = '0;
            count_in  = '0;
            commit_in = 1'b1;
            unique case (reg_sel_type'(addr[14:13]))
               SEL_CONTROL:  bank_in.control  = shift_new;
               SEL_CHR_LOW:  bank_in.chr_low  = shift_new;
               SEL_CHR_HIGH: bank_in.chr_high = shift_new;
               SEL_PRG:      bank_in.prg      = shift_new;
               default:      bank_in.prg      = shift_new;
            endcase
         end else begin
            shift_in = shift_new;
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff         <= '0;
         count_ff         <= '0;
         bank_ff.control  <= CONTROL_RESET;
         bank_ff.chr_low  <= BANK_RESET;
         bank_ff.chr_high <= BANK_RESET;
         bank_ff.prg      <= BANK_RESET;
      end else begin
         shift_ff <= shift_in;
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

   assign state     = bank_ff;
   assign mirroring = bank_in.control[1:0];
   assign committed = commit_in;

endmodule

### sv/slbm_xlate.sv
// PRG and CHR address translation through the current banking.
module slbm_xlate (
   input  slbm_pkg::kind_type                kind,
   input  logic [slbm_pkg::ADDR_W-1:0]       addr,
   input  slbm_pkg::bank_state_type          state,
   input  logic [slbm_pkg::PRG_MASK_W-1:0]   prg_mask,
   input  logic [slbm_pkg::CHR_MASK_W-1:0]   chr_mask,
   output logic [slbm_pkg::PHYS_W-1:0]       phys_addr
);
   import slbm_pkg::*;

   logic [PRG_MASK_W-1:0] prg, prg_pick;
   logic [CHR_MASK_W-1:0] chr_pick;
   logic                  slot, half;

   always_comb begin
      slot = addr[14];
      half = addr[12];
      prg  = state.prg[PRG_MASK_W-1:0];
      if (!state.control[3]) begin
         prg_pick = {prg[3:1], slot};
      end else if (!state.control[2]) begin
         prg_pick = slot ? prg : '0;
      end else begin
         prg_pick = slot ? prg_mask : prg;
      end
      prg_pick = prg_pick & prg_mask;

      if (!state.control[4]) begin
         chr_pick = {state.chr_low[4:1], half};
      end else begin
         chr_pick = half ? state.chr_high : state.chr_low;
      end
      chr_pick = chr_pick & chr_mask;

      case (kind)
         KIND_PRG: phys_addr = {prg_pick, addr[13:0]};
         KIND_CHR: phys_addr = {1'b0, chr_pick, addr[11:0]};
         default:  phys_addr = '0;
      endcase
   end

endmodule

### sv/serial_loaded_bank_mapper_top.sv
// Top level of the serial-loaded bank mapper: request register, work, result register.
// A request waits in the request register until the result register is free.
// Throughput: one request per cycle unless stalled by rsp_tready; a two-stage pipe.
// Reset: synchronous, clears both stage valids, the shift count and the bank registers
// (control 0x0C, banks all ones) and loads the bank masks (PRG 7, CHR 1).
module serial_loaded_bank_mapper_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slbm_pkg::REQ_DATA_W-1:0]     req_tdata,  // addr[15:0], value[23:16]
   input  logic [1:0]                          req_tuser,  // kind[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slbm_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // phys_addr[17:0], mirroring[19:18],
                                                           // committed[20], zero[23:21]
   input  logic                                csr_we,
   input  logic [slbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slbm_pkg::CHR_MASK_W-1:0]     csr_wdata
);
   import slbm_pkg::*;

   logic                  stage_valid_ff, stage_valid_in;
   kind_type              kind_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [PHYS_W-1:0]     phys_ff;
   logic [1:0]            mirror_ff;
   logic                  commit_ff;
   logic [PRG_MASK_W-1:0] prg_mask_ff;
   logic [CHR_MASK_W-1:0] chr_mask_ff;

   logic                  out_ready, process, accept;
   bank_state_type        state;
   logic [1:0]            mirroring;
   logic                  committed;
   logic [PHYS_W-1:0]     phys_addr;

   assign out_ready      = !out_valid_ff || rsp_tready;
   assign req_tready     = !stage_valid_ff || out_ready;
   assign accept         = req_tvalid && req_tready;
   assign process        = stage_valid_ff && out_ready;
   assign stage_valid_in = accept || (stage_valid_ff && !out_ready);
   assign out_valid_in   = process || (out_valid_ff && !rsp_tready);

   slbm_loader u_loader (
      .clock     (clock),
      .reset     (reset),
      .process   (process),
      .kind      (kind_ff),
      .addr      (addr_ff),
      .value     (value_ff),
      .state     (state),
      .mirroring (mirroring),
      .committed (committed)
   );

   slbm_xlate u_xlate (
      .kind      (kind_ff),
      .addr      (addr_ff),
      .state     (state),
      .prg_mask  (prg_mask_ff),
      .chr_mask  (chr_mask_ff),
      .phys_addr (phys_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         prg_mask_ff    <= PRG_MASK_RESET;
         chr_mask_ff    <= CHR_MASK_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PRG_MASK: prg_mask_ff <= csr_wdata[PRG_MASK_W-1:0];
               CSR_CHR_MASK: chr_mask_ff <= csr_wdata;
               default:      chr_mask_ff <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_type'(req_tuser);
         addr_ff  <= req_tdata[ADDR_W-1:0];
         value_ff <= req_tdata[ADDR_W +: VALUE_W];
      end
      if (process) begin
         phys_ff   <= phys_addr;
         mirror_ff <= mirroring;
         commit_ff <= committed;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, commit_ff, mirror_ff, phys_ff};

endmodule

### sv/slbm_checker.sv
// Port-level checks for the serial-loaded bank mapper, bound to the top level.
module slbm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [slbm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import slbm_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_commit_no_phys: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[PHYS_W-1:0] == '0)
      else $error("committed write carries an address");

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with result side free");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("request result missing");

endmodule

bind serial_loaded_bank_mapper_top slbm_checker u_slbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
